// ----- design/rsi_pkg.sv -----
package rsi_pkg;

    // Divider and square root pipelines: four result bits per stage
    localparam int DIV_BITS   = 32;
    localparam int DIV_PER    = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_PER;
    localparam int SQ_BITS    = 32;
    localparam int SQ_PER     = 4;
    localparam int SQ_STAGES  = SQ_BITS / SQ_PER;

    // Register stage numbers of the main pipeline
    localparam int ST_OC    = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_ABC   = 2;
    localparam int ST_DMUL  = 3;
    localparam int ST_DISC  = 4;
    localparam int ST_SQ0   = 5;
    localparam int ST_NUM   = ST_SQ0 + SQ_STAGES;
    localparam int ST_SEL   = ST_NUM + DIV_STAGES + 1;
    localparam int ST_TMUL  = ST_SEL + 1;
    localparam int ST_PNT   = ST_TMUL + 1;
    localparam int ST_DIFF  = ST_PNT + 1;
    localparam int ST_OUT   = ST_DIFF + DIV_STAGES + 1;
    localparam int N_STAGES = ST_OUT + 1;

    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_MATERIAL = 3'd4
    } cfg_reg_t;

    // Everything one ray carries down the pipeline
    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
        logic [2:0][31:0] oc;
        logic [31:0]      tlo;
        logic [31:0]      thi;
        logic [2:0][63:0] paa;
        logic [2:0][63:0] pbb;
        logic [2:0][63:0] pcc;
        logic [63:0]      prr;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      c;
        logic [63:0]      bb;
        logic [63:0]      ac;
        logic [63:0]      disc;
        logic             ok;
        logic [35:0]      srem;
        logic [31:0]      sroot;
        logic [1:0][32:0] nmag;
        logic [1:0]       nneg;
        logic             hit;
        logic [31:0]      t;
        logic [2:0][63:0] td;
        logic [2:0][31:0] p;
        logic [2:0][32:0] dmag;
        logic [2:0]       pneg;
        logic [2:0][31:0] nrm;
        logic [7:0]       mat;
    } pipe_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7fff_ffff)
            return MAX32;
        if (x < -64'sh0000_0000_8000_0000)
            return MIN32;
        return x[31:0];
    endfunction

    function automatic logic [31:0] symclamp(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7fff_ffff)
            return MAX32;
        if (x < -64'sh0000_0000_7fff_ffff)
            return 32'h8000_0001;
        return x[31:0];
    endfunction

endpackage

// ----- design/rsi_div_pipe.sv -----
module rsi_div_pipe (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo,
    output logic        ovf
);
    import rsi_pkg::*;

    logic [31:0] rem_reg  [DIV_STAGES];
    logic [31:0] rem_next [DIV_STAGES];
    logic [31:0] low_reg  [DIV_STAGES];
    logic [31:0] low_next [DIV_STAGES];
    logic [31:0] quo_reg  [DIV_STAGES];
    logic [31:0] quo_next [DIV_STAGES];
    logic [31:0] den_reg  [DIV_STAGES];
    logic [31:0] den_next [DIV_STAGES];
    logic        ovf_reg  [DIV_STAGES];
    logic        ovf_next [DIV_STAGES];

    // Restoring long division, high word is the starting remainder
    always_comb
    begin
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] q;
        logic [31:0] dv;
        logic        ov;
        logic [32:0] trial;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem = num[63:32];
                low = num[31:0];
                q   = '0;
                dv  = den;
                ov  = (num[63:32] >= den);
            end
            else
            begin
                rem = rem_reg[s-1];
                low = low_reg[s-1];
                q   = quo_reg[s-1];
                dv  = den_reg[s-1];
                ov  = ovf_reg[s-1];
            end
            for (int k = 0; k < DIV_PER; k++)
            begin
                trial = {rem, low[31]};
                low   = {low[30:0], 1'b0};
                if (trial >= {1'b0, dv})
                begin
                    rem = 32'(trial - {1'b0, dv});
                    q   = {q[30:0], 1'b1};
                end
                else
                begin
                    rem = trial[31:0];
                    q   = {q[30:0], 1'b0};
                end
            end
            rem_next[s] = rem;
            low_next[s] = low;
            quo_next[s] = q;
            den_next[s] = dv;
            ovf_next[s] = ov;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
            den_reg <= den_next;
            ovf_reg <= ovf_next;
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];
    assign ovf = ovf_reg[DIV_STAGES-1];

endmodule

// ----- design/ray_sphere_intersect_unit.sv -----
// Ray/sphere intersection in signed fixed point (FRAC_BITS fraction bits). One ray beat is
// accepted every cycle while the result beat is not held; the depth is set by the
// 8-stage square-root pipeline, the 8-stage root dividers and the 8-stage normal dividers,
// each retiring four bits per stage. A stalled result holds the whole pipeline in place, so
// nothing is lost or repeated. Sphere centre, radius and material come from the write port
// and must only change while no ray is in flight. A miss returns all-zero fields.
module ray_sphere_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        ray_valid,
    output logic        ray_ready,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [31:0] origin_z,
    input  logic [31:0] dir_x,
    input  logic [31:0] dir_y,
    input  logic [31:0] dir_z,
    input  logic [31:0] t_lower,
    input  logic [31:0] t_upper,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        hit,
    output logic [31:0] hit_t,
    output logic [31:0] point_x,
    output logic [31:0] point_y,
    output logic [31:0] point_z,
    output logic [31:0] normal_x,
    output logic [31:0] normal_y,
    output logic [31:0] normal_z,
    output logic [7:0]  hit_material
);
    import rsi_pkg::*;

    localparam logic [30:0] RADIUS_RESET = 31'(1) << (FRAC_BITS - 1);

    logic [31:0] cen_reg [3];
    logic [30:0] rad_reg;
    logic [7:0]  mat_reg;

    pipe_t pipe_reg  [N_STAGES];
    pipe_t pipe_next [N_STAGES];
    logic  vld_reg   [N_STAGES];
    logic  adv;

    logic [31:0] rq   [2];
    logic        rovf [2];
    logic [31:0] nq   [3];
    logic        novf [3];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg[0] <= '0;
            cen_reg[1] <= '0;
            cen_reg[2] <= '0;
            rad_reg    <= RADIUS_RESET;
            mat_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: cen_reg[0] <= cfg_data;
                REG_CENTER_Y: cen_reg[1] <= cfg_data;
                REG_CENTER_Z: cen_reg[2] <= cfg_data;
                REG_RADIUS:   rad_reg    <= cfg_data[30:0];
                REG_MATERIAL: mat_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves unless the output beat is held
    assign adv       = !vld_reg[ST_OUT] || res_ready;
    assign ray_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < N_STAGES; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= ray_valid;
            for (int s = 1; s < N_STAGES; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pipe_reg <= pipe_next;
    end

    // Root dividers: |num| * 2^F / a
    for (genvar k = 0; k < 2; k++)
    begin : g_root_div
        rsi_div_pipe u_div (
            .clk (clk),
            .en  (adv),
            .num (64'(pipe_reg[ST_NUM].nmag[k]) << FRAC_BITS),
            .den (pipe_reg[ST_NUM].a),
            .quo (rq[k]),
            .ovf (rovf[k])
        );
    end

    // Normal dividers: |P - C| * 2^F / R
    for (genvar i = 0; i < 3; i++)
    begin : g_norm_div
        rsi_div_pipe u_div (
            .clk (clk),
            .en  (adv),
            .num (64'(pipe_reg[ST_DIFF].dmag[i]) << FRAC_BITS),
            .den ({1'b0, rad_reg}),
            .quo (nq[i]),
            .ovf (novf[i])
        );
    end

    always_comb
    begin
        pipe_t              cur;
        logic signed [32:0] dif;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic signed [63:0] sc;
        logic [61:0]        rr;
        logic [35:0]        rem;
        logic [31:0]        root;
        logic [35:0]        trial;
        int                 idx;
        logic signed [34:0] nb;
        logic signed [34:0] nm;
        logic signed [33:0] qs [2];
        logic [1:0]         pass;

        // oc = O - C, saturated
        pipe_next[ST_OC]     = '0;
        pipe_next[ST_OC].o   = {origin_z, origin_y, origin_x};
        pipe_next[ST_OC].d   = {dir_z, dir_y, dir_x};
        pipe_next[ST_OC].tlo = t_lower;
        pipe_next[ST_OC].thi = t_upper;
        for (int i = 0; i < 3; i++)
        begin
            dif = $signed({pipe_next[ST_OC].o[i][31], pipe_next[ST_OC].o[i]})
                - $signed({cen_reg[i][31], cen_reg[i]});
            pipe_next[ST_OC].oc[i] = sat32(64'(dif));
        end

        // Dot product terms
        cur = pipe_reg[ST_OC];
        pipe_next[ST_MUL] = cur;
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_MUL].paa[i] = $signed(cur.d[i]) * $signed(cur.d[i]);
            pipe_next[ST_MUL].pbb[i] = $signed(cur.oc[i]) * $signed(cur.d[i]);
            pipe_next[ST_MUL].pcc[i] = $signed(cur.oc[i]) * $signed(cur.oc[i]);
        end
        rr = rad_reg * rad_reg;
        pipe_next[ST_MUL].prr = 64'(rr);

        // a, b, c: floored sums, clamped
        cur = pipe_reg[ST_MUL];
        pipe_next[ST_ABC] = cur;
        sa = ($signed(cur.paa[0]) >>> FRAC_BITS) + ($signed(cur.paa[1]) >>> FRAC_BITS)
           + ($signed(cur.paa[2]) >>> FRAC_BITS);
        sb = ($signed(cur.pbb[0]) >>> FRAC_BITS) + ($signed(cur.pbb[1]) >>> FRAC_BITS)
           + ($signed(cur.pbb[2]) >>> FRAC_BITS);
        sc = ($signed(cur.pcc[0]) >>> FRAC_BITS) + ($signed(cur.pcc[1]) >>> FRAC_BITS)
           + ($signed(cur.pcc[2]) >>> FRAC_BITS) - ($signed(cur.prr) >>> FRAC_BITS);
        pipe_next[ST_ABC].a = symclamp(sa);
        pipe_next[ST_ABC].b = symclamp(sb);
        pipe_next[ST_ABC].c = symclamp(sc);

        // b*b and a*c
        cur = pipe_reg[ST_ABC];
        pipe_next[ST_DMUL] = cur;
        pipe_next[ST_DMUL].bb = $signed(cur.b) * $signed(cur.b);
        pipe_next[ST_DMUL].ac = $signed(cur.a) * $signed(cur.c);

        // Discriminant
        cur = pipe_reg[ST_DMUL];
        pipe_next[ST_DISC]       = cur;
        pipe_next[ST_DISC].disc  = cur.bb - cur.ac;
        pipe_next[ST_DISC].ok    = ($signed(pipe_next[ST_DISC].disc) > 64'sd0)
                                && ($signed(cur.a) > 32'sd0);
        pipe_next[ST_DISC].srem  = '0;
        pipe_next[ST_DISC].sroot = '0;

        // Integer square root, two radicand bits per step
        for (int j = 0; j < SQ_STAGES; j++)
        begin
            cur  = pipe_reg[ST_SQ0 + j - 1];
            rem  = cur.srem;
            root = cur.sroot;
            for (int k = 0; k < SQ_PER; k++)
            begin
                idx   = SQ_BITS - 1 - (j * SQ_PER + k);
                rem   = {rem[33:0], cur.disc[2*idx +: 2]};
                trial = {2'b00, root, 2'b01};
                if (rem >= trial)
                begin
                    rem  = rem - trial;
                    root = {root[30:0], 1'b1};
                end
                else
                begin
                    root = {root[30:0], 1'b0};
                end
            end
            pipe_next[ST_SQ0 + j]       = cur;
            pipe_next[ST_SQ0 + j].srem  = rem;
            pipe_next[ST_SQ0 + j].sroot = root;
        end

        // Root numerators -b - s and -b + s as sign and magnitude
        cur = pipe_reg[ST_NUM - 1];
        pipe_next[ST_NUM] = cur;
        nb = -35'(signed'(cur.b));
        for (int k = 0; k < 2; k++)
        begin
            nm = (k == 0) ? nb - $signed({3'b000, cur.sroot})
                          : nb + $signed({3'b000, cur.sroot});
            pipe_next[ST_NUM].nneg[k] = nm[34];
            pipe_next[ST_NUM].nmag[k] = nm[34] ? 33'(-nm) : nm[32:0];
        end

        // Middle stages only carry the beat past the dividers
        for (int s = ST_NUM + 1; s < ST_SEL; s++)
            pipe_next[s] = pipe_reg[s-1];

        // Window test, nearer root first
        cur = pipe_reg[ST_SEL - 1];
        pipe_next[ST_SEL] = cur;
        for (int k = 0; k < 2; k++)
        begin
            qs[k]   = cur.nneg[k] ? -$signed({2'b00, rq[k]}) : $signed({2'b00, rq[k]});
            pass[k] = !rovf[k] && (qs[k] > 34'(signed'(cur.tlo)))
                   && (qs[k] < 34'(signed'(cur.thi)));
        end
        pipe_next[ST_SEL].hit = cur.ok && (pass[0] || pass[1]);
        pipe_next[ST_SEL].t   = pass[0] ? qs[0][31:0] : qs[1][31:0];

        // t * D
        cur = pipe_reg[ST_SEL];
        pipe_next[ST_TMUL] = cur;
        for (int i = 0; i < 3; i++)
            pipe_next[ST_TMUL].td[i] = $signed(cur.t) * $signed(cur.d[i]);

        // Hit point
        cur = pipe_reg[ST_TMUL];
        pipe_next[ST_PNT] = cur;
        for (int i = 0; i < 3; i++)
            pipe_next[ST_PNT].p[i] = sat32(64'(signed'(cur.o[i]))
                                   + ($signed(cur.td[i]) >>> FRAC_BITS));

        // P - C as sign and magnitude
        cur = pipe_reg[ST_PNT];
        pipe_next[ST_DIFF] = cur;
        for (int i = 0; i < 3; i++)
        begin
            dif = $signed({cur.p[i][31], cur.p[i]}) - $signed({cen_reg[i][31], cen_reg[i]});
            pipe_next[ST_DIFF].pneg[i] = dif[32];
            pipe_next[ST_DIFF].dmag[i] = dif[32] ? 33'(-dif) : dif;
        end

        for (int s = ST_DIFF + 1; s < ST_OUT; s++)
            pipe_next[s] = pipe_reg[s-1];

        // Normal, saturated; zero fields on a miss
        cur = pipe_reg[ST_OUT - 1];
        pipe_next[ST_OUT]     = cur;
        pipe_next[ST_OUT].mat = mat_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (rad_reg == '0)
                pipe_next[ST_OUT].nrm[i] = '0;
            else if (novf[i] || nq[i][31])
                pipe_next[ST_OUT].nrm[i] = cur.pneg[i] ? MIN32 : MAX32;
            else
                pipe_next[ST_OUT].nrm[i] = cur.pneg[i] ? -nq[i] : nq[i];
        end
        if (!cur.hit)
        begin
            pipe_next[ST_OUT].t   = '0;
            pipe_next[ST_OUT].p   = '0;
            pipe_next[ST_OUT].nrm = '0;
            pipe_next[ST_OUT].mat = '0;
        end
    end

    assign res_valid    = vld_reg[ST_OUT];
    assign hit          = pipe_reg[ST_OUT].hit;
    assign hit_t        = pipe_reg[ST_OUT].t;
    assign point_x      = pipe_reg[ST_OUT].p[0];
    assign point_y      = pipe_reg[ST_OUT].p[1];
    assign point_z      = pipe_reg[ST_OUT].p[2];
    assign normal_x     = pipe_reg[ST_OUT].nrm[0];
    assign normal_y     = pipe_reg[ST_OUT].nrm[1];
    assign normal_z     = pipe_reg[ST_OUT].nrm[2];
    assign hit_material = pipe_reg[ST_OUT].mat;

endmodule

// ----- design/rsi_checker.sv -----
module rsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        ray_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        hit,
    input logic [31:0] hit_t,
    input logic [31:0] point_x,
    input logic [31:0] point_y,
    input logic [31:0] point_z,
    input logic [31:0] normal_x,
    input logic [31:0] normal_y,
    input logic [31:0] normal_z,
    input logic [7:0]  hit_material
);

    // Held result beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(hit) && $stable(hit_t)
            && $stable(point_x) && $stable(normal_x) && $stable(hit_material))
        else $error("result beat changed while stalled");

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> hit_t == '0 && point_x == '0 && point_y == '0
            && point_z == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0
            && hit_material == '0)
        else $error("miss with nonzero fields");

    // Input side only stalls when the output beat is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ray_ready == (!res_valid || res_ready))
        else $error("ray_ready does not follow the output stall");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result beat present right after reset");

endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import rsi_pkg::*;

    localparam int          FRAC       = 16;
    localparam int          CYCLE_CAP  = 500000;
    localparam int          DRAIN_WAIT = 45;
    localparam int          PHASE_RAYS = 400;
    localparam logic [2:0]  REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
        logic [31:0]      tlo;
        logic [31:0]      thi;
        logic             known_miss;
    } ray_t;

    typedef struct packed {
        logic             hit;
        logic [31:0]      t;
        logic [2:0][31:0] p;
        logic [2:0][31:0] n;
        logic [7:0]       mat;
    } hit_rec_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        ray_valid;
    logic        ray_ready;
    ray_t        ray_cur;
    logic        res_valid;
    logic        res_ready;
    hit_rec_t    res_got;

    // sphere registers as the checker sees them
    longint      sph_c [3];
    longint      sph_r;
    logic [7:0]  sph_mat;

    hit_rec_t    hits_pending[$];
    ray_t        dir_rows[$];
    int          mismatches;
    int          cycles;
    bit          idle_on;

    ray_sphere_intersect_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .ray_valid(ray_valid), .ray_ready(ray_ready),
        .origin_x(ray_cur.o[0]), .origin_y(ray_cur.o[1]), .origin_z(ray_cur.o[2]),
        .dir_x(ray_cur.d[0]), .dir_y(ray_cur.d[1]), .dir_z(ray_cur.d[2]),
        .t_lower(ray_cur.tlo), .t_upper(ray_cur.thi),
        .res_valid(res_valid), .res_ready(res_ready),
        .hit(res_got.hit), .hit_t(res_got.t),
        .point_x(res_got.p[0]), .point_y(res_got.p[1]), .point_z(res_got.p[2]),
        .normal_x(res_got.n[0]), .normal_y(res_got.n[1]), .normal_z(res_got.n[2]),
        .hit_material(res_got.mat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp31(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483647)
            return -64'sd2147483647;
        return x;
    endfunction

    // expected result of one ray against the current sphere
    function automatic hit_rec_t trace_ray(input ray_t r);
        longint o [3];
        longint d [3];
        longint oc [3];
        longint a, b, c, disc, s, num, q, t, tlo, thi, pt;
        longint unsigned rem, acc, bitv;
        bit found;
        hit_rec_t res;
        a = 0; b = 0; c = 0; t = 0; s = 0;
        found = 1'b0;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            o[i]  = longint'($signed(r.o[i]));
            d[i]  = longint'($signed(r.d[i]));
            oc[i] = clip32(o[i] - sph_c[i]);
            a += (d[i] * d[i]) >>> FRAC;
            b += (oc[i] * d[i]) >>> FRAC;
            c += (oc[i] * oc[i]) >>> FRAC;
        end
        tlo = longint'($signed(r.tlo));
        thi = longint'($signed(r.thi));
        c -= (sph_r * sph_r) >>> FRAC;
        a = clamp31(a);
        b = clamp31(b);
        c = clamp31(c);
        disc = b * b - a * c;
        if (disc > 0 && a > 0)
        begin
            // integer square root, bit by bit
            rem  = disc;
            acc  = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= acc + bitv)
                begin
                    rem = rem - (acc + bitv);
                    acc = (acc >> 1) + bitv;
                end
                else
                    acc = acc >> 1;
                bitv = bitv >> 2;
            end
            s = longint'(acc);
            // near root first, then far root
            for (int k = 0; k < 2 && !found; k++)
            begin
                num = (k == 0) ? (-b - s) : (-b + s);
                q = (num * 64'sd65536) / a;
                if (q > tlo && q < thi)
                begin
                    t = q;
                    found = 1'b1;
                end
            end
        end
        if (!found)
            return res;
        res.hit = 1'b1;
        res.t   = t[31:0];
        res.mat = sph_mat;
        for (int i = 0; i < 3; i++)
        begin
            pt = clip32(o[i] + ((t * d[i]) >>> FRAC));
            res.p[i] = pt[31:0];
            if (sph_r != 0)
                res.n[i] = 32'(clip32(((pt - sph_c[i]) * 64'sd65536) / sph_r));
        end
        return res;
    endfunction

    function automatic ray_t mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, lo, hi,
                                    input logic miss);
        ray_t r;
        r.o = {oz, oy, ox};
        r.d = {dz, dy, dx};
        r.tlo = lo;
        r.thi = hi;
        r.known_miss = miss;
        return r;
    endfunction

    function automatic logic [31:0] rnd_span(input int half);
        return $urandom_range(2 * half) - half;
    endfunction

    // mostly aimed rays near the sphere; a quarter raw noise
    function automatic ray_t gen_ray();
        ray_t r;
        logic [31:0] off;
        r = '0;
        if ($urandom_range(99) < 25)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.o[i] = $urandom;
                r.d[i] = $urandom;
            end
            r.tlo = $urandom;
            r.thi = $urandom;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            off = rnd_span(1 << 20);
            r.o[i] = sph_c[i][31:0] + off;
            r.d[i] = ($signed(-off) >>> $urandom_range(4)) + rnd_span(1 << 14);
        end
        case ($urandom_range(3))
            0: r.tlo = 32'h8000_0000;
            1: r.tlo = 32'h0;
            default: r.tlo = rnd_span(1 << 16);
        endcase
        r.thi = ($urandom_range(3) == 0) ? MAX32 : {1'b0, 31'($urandom)} >> $urandom_range(14);
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CENTER_X: sph_c[0] = longint'($signed(val));
            REG_CENTER_Y: sph_c[1] = longint'($signed(val));
            REG_CENTER_Z: sph_c[2] = longint'($signed(val));
            REG_RADIUS:   sph_r    = longint'(val[30:0]);
            REG_MATERIAL: sph_mat  = val[7:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sphere(input logic [31:0] cx, cy, cz, rad, input logic [7:0] mat);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_MATERIAL, {24'h0, mat});
    endtask

    // hold a ray beat until it is taken, with random gaps ahead of it while idle_on is set
    task automatic send_ray(input ray_t r);
        int gap;
        gap = 0;
        if (idle_on)
            while ($urandom_range(99) < 19)
                gap++;
        if (gap > 0)
        begin
            ray_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_cur   <= r;
        ray_valid <= 1'b1;
        do
            @(posedge clk);
        while (!ray_ready);
    endtask

    // drop valid right after the last accepted beat, then wait for all results
    task automatic drain();
        ray_valid <= 1'b0;
        @(posedge clk);
        while (hits_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // accept side: predict on ray beats, compare on result beats
    always @(posedge clk)
    begin
        hit_rec_t want;
        if (rst_n)
        begin
            res_ready <= idle_on ? ($urandom_range(99) >= 19) : 1'b1;
            if (ray_valid && ray_ready)
                hits_pending.push_back(ray_cur.known_miss ? hit_rec_t'('0) : trace_ray(ray_cur));
            if (res_valid && res_ready)
            begin
                if (hits_pending.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %h", res_got);
                end
                else
                begin
                    want = hits_pending.pop_front();
                    if (res_got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: hit %b/%b t %h/%h p %h/%h n %h/%h mat %h/%h",
                                     mismatches, want.hit, res_got.hit, want.t, res_got.t,
                                     want.p, res_got.p, want.n, res_got.n,
                                     want.mat, res_got.mat);
                    end
                end
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("ray_sphere_intersect_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_CENTER_X;
        cfg_data   = '0;
        ray_valid  = 1'b0;
        ray_cur    = '0;
        res_ready  = 1'b0;
        mismatches = 0;
        cycles     = 0;
        idle_on    = 1'b1;
        sph_c[0]   = 0;
        sph_c[1]   = 0;
        sph_c[2]   = 0;
        sph_r      = 32768;
        sph_mat    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed rays against the reset sphere
        dir_rows.push_back(mk_ray(0, 0, 32'hfffe_0000, 0, 0, 0, 0, MAX32, 1'b1));
        dir_rows.push_back(mk_ray(0, 0, 32'hfffe_0000, 0, 0, 32'h1_0000, 32'h1_0000, 0, 1'b1));
        dir_rows.push_back(mk_ray(0, 0, 32'hfffe_0000, 0, 0, 32'h1_0000, 5, 5, 1'b1));
        dir_rows.push_back(mk_ray(0, 0, 32'hfffe_0000, 0, 0, 32'h1_0000, 0, MAX32, 1'b0));
        dir_rows.push_back(mk_ray(0, 0, 0, 32'h1_0000, 0, 0, MIN32, MAX32, 1'b0));
        dir_rows.push_back(mk_ray(0, 0, 0, 32'h1_0000, 0, 0, 0, MAX32, 1'b0));
        dir_rows.push_back(mk_ray(0, 32'h8000, 32'hfffe_0000, 0, 0, 32'h1_0000, 0, MAX32, 1'b0));
        dir_rows.push_back(mk_ray(0, 32'h3_0000, 32'hfffe_0000, 0, 0, 32'h1_0000, 0, MAX32,
                                  1'b1));
        dir_rows.push_back(mk_ray(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32, MIN32, MAX32,
                                  1'b0));
        dir_rows.push_back(mk_ray(MAX32, MAX32, MAX32, MIN32, MIN32, MIN32, MIN32, MAX32,
                                  1'b0));
        dir_rows.push_back(mk_ray(MAX32, MIN32, 0, MIN32, MAX32, 1, MIN32, MAX32, 1'b0));
        dir_rows.push_back(mk_ray(32'h0002_0000, 0, 0, 32'hffff_0000, 0, 0, MIN32, MAX32,
                                  1'b0));
        dir_rows.push_back(mk_ray(0, 0, 32'hfffe_0000, 0, 0, 1, MIN32, MAX32, 1'b0));
        foreach (dir_rows[i])
            send_ray(dir_rows[i]);
        drain();

        // random phases, each under its own sphere
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_sphere(rnd_span(1 << 20), rnd_span(1 << 20), rnd_span(1 << 20),
                              $urandom_range(1, 1 << 19), $urandom);
                1: set_sphere(rnd_span(1 << 18), 0, rnd_span(1 << 18),
                              $urandom_range(1 << 12, 1 << 18), 8'h5a);
                2: set_sphere(MAX32, MIN32, 0, MAX32, 8'hff);
                3: set_sphere(rnd_span(1 << 16), rnd_span(1 << 16), 0, 0, 8'h00);
                default: set_sphere(MIN32, MAX32, rnd_span(1 << 8), 1, $urandom);
            endcase
            if (ph == 1)
                write_reg(REG_UNUSED, $urandom);
            idle_on = (ph != 1);
            for (int n = 0; n < PHASE_RAYS; n++)
            begin
                if (ph == 0 && n == PHASE_RAYS / 2)
                    drain();
                send_ray(gen_ray());
            end
            drain();
        end

        if (mismatches == 0)
            $display("ray_sphere_intersect_unit: match");
        else
            $display("ray_sphere_intersect_unit: mismatch");
        $finish;
    end

endmodule
